/* sv/tftp_receive_engine_defines.svh */
// ---------------------------------------------------------------------------
// TFTP receive engine assertion macros
// Concurrent assertion helpers used by the receive engine core.
// ---------------------------------------------------------------------------
`ifndef TFTP_RECEIVE_ENGINE_DEFINES_SVH
`define TFTP_RECEIVE_ENGINE_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define TRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TRE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/tftp_re_pkg.sv */
// ---------------------------------------------------------------------------
// TFTP receive engine package
// Item types and protocol constants shared by the receive engine modules.
// ---------------------------------------------------------------------------
package tftp_re_pkg;

  localparam int unsigned AddrW = 25;
  localparam int unsigned PortW = 16;
  localparam int unsigned WordW = 16;

  localparam logic [WordW-1:0] OpData  = 16'd3;
  localparam logic [WordW-1:0] OpAck   = 16'd4;
  localparam logic [WordW-1:0] OpError = 16'd5;

  localparam logic [WordW-1:0] HdrLen    = 16'd4;
  localparam logic [WordW-1:0] PosMax    = 16'hFFFF;
  localparam logic [PortW-1:0] ResetPort = 16'd7642;
  localparam logic [AddrW-1:0] TotalMax  = 25'h1FF_FFFF;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             first_byte;
    logic             last_byte;
    logic [PortW-1:0] source_port;
    logic [PortW-1:0] dest_port;
  } in_item_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] write_addr;
    logic [7:0]       write_data;
    logic             send_ack;
    logic [PortW-1:0] reply_port;
    logic [WordW-1:0] reply_block;
    logic [AddrW-1:0] received_bytes;
    logic             finished;
    logic             error;
    logic [WordW-1:0] acked_block;
    logic             acked_valid;
    logic [PortW-1:0] peer_data_port;
  } out_item_t;

endpackage

/* sv/tftp_re_in_stage.sv */
// ---------------------------------------------------------------------------
// TFTP receive engine input stage
// Registers one incoming item and releases it when the result side has room.
// ---------------------------------------------------------------------------
module tftp_re_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tftp_re_pkg::in_item_t in_item_i,
  input  logic                  ready_i,
  output logic                  fire_o,
  output tftp_re_pkg::in_item_t item_o
);

  logic                  valid_q;
  tftp_re_pkg::in_item_t item_q;
  logic                  take;

  assign fire_o     = valid_q && ready_i;
  assign in_stall_o = valid_q && !ready_i;
  assign take       = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (fire_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

endmodule

/* sv/tftp_re_core.sv */
// ---------------------------------------------------------------------------
// TFTP receive engine core
// Packet framing, header decode, memory write and transfer state update.
// ---------------------------------------------------------------------------
`include "tftp_receive_engine_defines.svh"

module tftp_re_core #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tftp_re_pkg::PortW-1:0]       cfg_wdata_i,
  input  logic                                fire_i,
  input  tftp_re_pkg::in_item_t               item_i,
  output tftp_re_pkg::out_item_t              res_o
);

  localparam int unsigned AW = tftp_re_pkg::AddrW;
  localparam int unsigned WW = tftp_re_pkg::WordW;
  localparam logic [AW-1:0] BlockBytesA = AW'(BLOCK_BYTES);
  localparam logic [WW-1:0] BlockBytesW = WW'(BLOCK_BYTES);

  logic [tftp_re_pkg::PortW-1:0] local_port_q;
  logic [WW-1:0] byte_count_q, byte_count_d;
  logic [WW-1:0] opcode_q, opcode_d;
  logic [WW-1:0] block_q, block_d;
  logic [AW-1:0] total_q, total_d;
  logic          done_q, done_d;
  logic          error_q, error_d;
  logic [WW-1:0] ack_block_q, ack_block_d;
  logic          ack_seen_q, ack_seen_d;
  logic [tftp_re_pkg::PortW-1:0] peer_q, peer_d;
  logic [AW-1:0] base_q, base_d;

  logic [WW-1:0] pos;
  logic          port_ok;
  logic          in_body;
  logic          at_end;
  logic          block_nz;
  logic [WW-1:0] len;
  logic [AW:0]   sum;
  logic [WW-1:0] blk_m1;

  assign pos      = item_i.first_byte ? '0 : byte_count_q;
  assign port_ok  = item_i.dest_port == local_port_q;
  assign in_body  = pos >= tftp_re_pkg::HdrLen;
  assign at_end   = item_i.last_byte && port_ok && (pos >= tftp_re_pkg::HdrLen - 16'd1);
  assign block_nz = block_d != '0;
  assign len      = pos + 16'd1 - tftp_re_pkg::HdrLen;
  assign sum      = {1'b0, total_q} + (AW + 1)'(len);
  assign blk_m1   = block_d - 16'd1;
  assign base_d   = AW'(blk_m1) * BlockBytesA;

  always_comb begin
    opcode_d = opcode_q;
    block_d  = block_q;
    unique case (pos)
      16'd0:   opcode_d = {item_i.payload_byte, 8'h00};
      16'd1:   opcode_d = {opcode_q[15:8], item_i.payload_byte};
      16'd2:   block_d  = {item_i.payload_byte, 8'h00};
      16'd3:   block_d  = {block_q[15:8], item_i.payload_byte};
      default: ;
    endcase
  end

  always_comb begin
    total_d     = total_q;
    done_d      = done_q;
    error_d     = error_q;
    ack_block_d = ack_block_q;
    ack_seen_d  = ack_seen_q;
    peer_d      = peer_q;
    res_o       = '0;

    if (in_body && port_ok && opcode_d == tftp_re_pkg::OpData && block_nz) begin
      res_o.write_enable = 1'b1;
      res_o.write_addr   = base_q + AW'(pos - tftp_re_pkg::HdrLen);
      res_o.write_data   = item_i.payload_byte;
    end

    if (at_end) begin
      if (opcode_d == tftp_re_pkg::OpAck) begin
        peer_d      = item_i.source_port;
        ack_block_d = block_d;
        ack_seen_d  = 1'b1;
      end else if (block_nz && opcode_d == tftp_re_pkg::OpData) begin
        total_d = sum[AW] ? tftp_re_pkg::TotalMax : sum[AW-1:0];
        if (len < BlockBytesW) begin
          done_d = 1'b1;
        end
        res_o.send_ack    = 1'b1;
        res_o.reply_port  = item_i.source_port;
        res_o.reply_block = block_d;
      end else if (block_nz && opcode_d == tftp_re_pkg::OpError) begin
        error_d = 1'b1;
        done_d  = 1'b1;
      end
    end

    if (item_i.last_byte) begin
      byte_count_d = '0;
    end else if (pos == tftp_re_pkg::PosMax) begin
      byte_count_d = tftp_re_pkg::PosMax;
    end else begin
      byte_count_d = pos + 16'd1;
    end

    res_o.received_bytes = total_d;
    res_o.finished       = done_d;
    res_o.error          = error_d;
    res_o.acked_block    = ack_block_d;
    res_o.acked_valid    = ack_seen_d;
    res_o.peer_data_port = peer_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_port_q <= tftp_re_pkg::ResetPort;
    end else if (cfg_we_i) begin
      local_port_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      opcode_q     <= '0;
      block_q      <= '0;
      total_q      <= '0;
      done_q       <= 1'b0;
      error_q      <= 1'b0;
      ack_block_q  <= '0;
      ack_seen_q   <= 1'b0;
      peer_q       <= '0;
    end else if (fire_i) begin
      byte_count_q <= byte_count_d;
      opcode_q     <= opcode_d;
      block_q      <= block_d;
      total_q      <= total_d;
      done_q       <= done_d;
      error_q      <= error_d;
      ack_block_q  <= ack_block_d;
      ack_seen_q   <= ack_seen_d;
      peer_q       <= peer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && pos == tftp_re_pkg::HdrLen - 16'd1) begin
      base_q <= base_d;
    end
  end

  `TRE_ASSERT(a_write_advances, fire_i && res_o.write_enable && !item_i.last_byte |=> byte_count_q > tftp_re_pkg::HdrLen, "Write did not advance the byte position.")
  `TRE_ASSERT(a_total_monotonic, 1'b1 |=> total_q >= $past(total_q), "Received byte total decreased.")
  `TRE_ASSERT(a_error_done, error_q |-> done_q, "Error flag set without finished flag.")
  `TRE_ASSERT(a_ack_block_nz, fire_i && res_o.send_ack |-> res_o.reply_block != '0, "Acknowledge requested for block zero.")

endmodule

/* sv/tftp_re_out_stage.sv */
// ---------------------------------------------------------------------------
// TFTP receive engine output stage
// Holds one result item until the downstream side takes it.
// ---------------------------------------------------------------------------
module tftp_re_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  tftp_re_pkg::out_item_t res_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tftp_re_pkg::out_item_t out_item_o
);

  logic                   valid_q;
  tftp_re_pkg::out_item_t res_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* sv/tftp_receive_engine.sv */
// ---------------------------------------------------------------------------
// TFTP receive engine
// An accepted item is registered in the input stage and its result in the output stage.
// Throughput: one item per cycle while the output is not stalled; the byte position
// and header registers close their update loop between input and result stages.
// Reset clears all transfer state and sets the local port to 7642.
// ---------------------------------------------------------------------------
module tftp_receive_engine #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tftp_re_pkg::PortW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tftp_re_pkg::in_item_t         in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tftp_re_pkg::out_item_t        out_item_o
);

  logic                   ready;
  logic                   fire;
  tftp_re_pkg::in_item_t  item;
  tftp_re_pkg::out_item_t res;

  tftp_re_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .ready_i    (ready),
    .fire_o     (fire),
    .item_o     (item)
  );

  tftp_re_core #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .res_o       (res)
  );

  tftp_re_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* sim/tftp_re_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// TFTP receive engine checker
// Watches the configuration port and both item channels of the receive
// engine. Every accepted input byte is run through a cycle-free model of the
// engine, and the predicted result is queued. Every accepted result is
// compared field by field with the oldest queued prediction. Mismatches are
// printed and counted, and the number of outstanding predictions is exported.
// ---------------------------------------------------------------------------
module tftp_re_checker #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tftp_re_pkg::PortW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  tftp_re_pkg::in_item_t         in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  tftp_re_pkg::out_item_t        out_item_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  logic [tftp_re_pkg::PortW-1:0] local_port_q;
  logic [tftp_re_pkg::WordW-1:0] pos_q;
  logic [tftp_re_pkg::WordW-1:0] opcode_q;
  logic [tftp_re_pkg::WordW-1:0] block_q;
  logic [tftp_re_pkg::AddrW-1:0] total_q;
  logic                          done_q;
  logic                          error_q;
  logic [tftp_re_pkg::WordW-1:0] ack_block_q;
  logic                          ack_seen_q;
  logic [tftp_re_pkg::PortW-1:0] peer_port_q;

  tftp_re_pkg::out_item_t pending_results[$];

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  task automatic absorb_byte(input tftp_re_pkg::in_item_t it);
    logic [tftp_re_pkg::WordW-1:0] pos;
    logic                          port_ok;
    logic [31:0]                   addr;
    logic [31:0]                   len;
    logic [31:0]                   sum;
    tftp_re_pkg::out_item_t        r;
    r = '0;
    port_ok = (it.dest_port == local_port_q);
    pos = it.first_byte ? '0 : pos_q;
    case (pos)
      16'd0: opcode_q = {it.payload_byte, 8'h00};
      16'd1: opcode_q = {opcode_q[15:8], it.payload_byte};
      16'd2: block_q = {it.payload_byte, 8'h00};
      16'd3: block_q = {block_q[15:8], it.payload_byte};
      default: ;
    endcase
    if (pos >= tftp_re_pkg::HdrLen && port_ok && opcode_q == tftp_re_pkg::OpData &&
        block_q != '0) begin
      addr = (32'(block_q) - 32'd1) * BLOCK_BYTES + 32'(pos) - 32'(tftp_re_pkg::HdrLen);
      r.write_enable = 1'b1;
      r.write_addr = addr[tftp_re_pkg::AddrW-1:0];
      r.write_data = it.payload_byte;
    end
    if (it.last_byte && port_ok && pos >= tftp_re_pkg::HdrLen - 16'd1) begin
      if (opcode_q == tftp_re_pkg::OpAck) begin
        peer_port_q = it.source_port;
        ack_block_q = block_q;
        ack_seen_q = 1'b1;
      end else if (block_q != '0 && opcode_q == tftp_re_pkg::OpData) begin
        len = 32'(pos) + 32'd1 - 32'(tftp_re_pkg::HdrLen);
        sum = 32'(total_q) + len;
        total_q = (sum > 32'(tftp_re_pkg::TotalMax)) ? tftp_re_pkg::TotalMax :
                  sum[tftp_re_pkg::AddrW-1:0];
        if (len < BLOCK_BYTES) begin
          done_q = 1'b1;
        end
        r.send_ack = 1'b1;
        r.reply_port = it.source_port;
        r.reply_block = block_q;
      end else if (block_q != '0 && opcode_q == tftp_re_pkg::OpError) begin
        error_q = 1'b1;
        done_q = 1'b1;
      end
    end
    if (it.last_byte) begin
      pos_q = '0;
    end else begin
      pos_q = (pos == tftp_re_pkg::PosMax) ? tftp_re_pkg::PosMax : pos + 16'd1;
    end
    r.received_bytes = total_q;
    r.finished = done_q;
    r.error = error_q;
    r.acked_block = ack_block_q;
    r.acked_valid = ack_seen_q;
    r.peer_data_port = peer_port_q;
    pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_port_q = tftp_re_pkg::ResetPort;
      pos_q = '0;
      opcode_q = '0;
      block_q = '0;
      total_q = '0;
      done_q = 1'b0;
      error_q = 1'b0;
      ack_block_q = '0;
      ack_seen_q = 1'b0;
      peer_port_q = '0;
      pending_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, out_item_i);
          fail_count_o++;
        end else begin
          check_field("write_enable", pending_results[0].write_enable, out_item_i.write_enable);
          check_field("write_addr", pending_results[0].write_addr, out_item_i.write_addr);
          check_field("write_data", pending_results[0].write_data, out_item_i.write_data);
          check_field("send_ack", pending_results[0].send_ack, out_item_i.send_ack);
          check_field("reply_port", pending_results[0].reply_port, out_item_i.reply_port);
          check_field("reply_block", pending_results[0].reply_block, out_item_i.reply_block);
          check_field("received_bytes", pending_results[0].received_bytes,
                      out_item_i.received_bytes);
          check_field("finished", pending_results[0].finished, out_item_i.finished);
          check_field("error", pending_results[0].error, out_item_i.error);
          check_field("acked_block", pending_results[0].acked_block, out_item_i.acked_block);
          check_field("acked_valid", pending_results[0].acked_valid, out_item_i.acked_valid);
          check_field("peer_data_port", pending_results[0].peer_data_port,
                      out_item_i.peer_data_port);
          void'(pending_results.pop_front());
        end
      end
      if (cfg_we_i) begin
        local_port_q = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_byte(in_item_i);
      end
    end
    pending_o = pending_results.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// TFTP receive engine testbench
// Feeds the engine with UDP payload bytes: a short directed set of packets,
// then random traffic made mostly of well-formed TFTP packets, with noise,
// broken framing and wrong ports mixed in, under several local port settings.
// One data packet for the highest block number is sent with neither side
// idling. Both channels idle and stall at random, and the receiver holds off
// once for a long stretch. A checker module predicts and compares every
// result.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned BlockBytes = 512;
  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 6;
  localparam int QuietBytes = 100;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [tftp_re_pkg::PortW-1:0] cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  tftp_re_pkg::in_item_t         in_item_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  tftp_re_pkg::out_item_t        out_item_o;

  int                            fail_count;
  int                            pending;
  int                            cycle_count = 0;
  logic [tftp_re_pkg::PortW-1:0] cur_port = tftp_re_pkg::ResetPort;
  bit                            quiet = 1'b0;
  bit                            want_hold = 1'b0;
  bit                            hold_done = 1'b0;

  always #6 clk_i = ~clk_i;

  tftp_receive_engine #(
    .BLOCK_BYTES(BlockBytes)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  tftp_re_checker #(
    .BLOCK_BYTES(BlockBytes)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver stalls at random, except during the quiet packet and for one long
  // hold-off that it counts out on its own while the sender keeps offering bytes.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (want_hold && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 32);
      end
    end
  end

  task automatic push_byte(input tftp_re_pkg::in_item_t it);
    if (!quiet) begin
      while ($urandom_range(99) < 32) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_packet(input logic [tftp_re_pkg::WordW-1:0] op,
                             input logic [tftp_re_pkg::WordW-1:0] blk,
                             input int nbytes, input logic [tftp_re_pkg::PortW-1:0] dport,
                             input bit with_first, input int bad_at);
    tftp_re_pkg::in_item_t         it;
    logic [tftp_re_pkg::PortW-1:0] sport;
    sport = tftp_re_pkg::PortW'($urandom_range(65535));
    for (int i = 0; i < nbytes; i++) begin
      it.first_byte = with_first && (i == 0);
      it.last_byte = (i == nbytes - 1);
      it.source_port = sport;
      it.dest_port = (i == bad_at) ?
                     dport ^ tftp_re_pkg::PortW'($urandom_range(1, 65535)) : dport;
      case (i)
        0: it.payload_byte = op[15:8];
        1: it.payload_byte = op[7:0];
        2: it.payload_byte = blk[15:8];
        3: it.payload_byte = blk[7:0];
        default: it.payload_byte = 8'($urandom_range(255));
      endcase
      push_byte(it);
    end
  endtask

  task automatic random_traffic(input int budget);
    int                            sent;
    int                            k;
    int                            nbytes;
    logic [tftp_re_pkg::WordW-1:0] op;
    logic [tftp_re_pkg::WordW-1:0] blk;
    logic [tftp_re_pkg::PortW-1:0] dport;
    tftp_re_pkg::in_item_t         it;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 8) begin
        it.payload_byte = 8'($urandom_range(255));
        it.first_byte = ($urandom_range(3) == 0);
        it.last_byte = ($urandom_range(3) == 0);
        it.source_port = tftp_re_pkg::PortW'($urandom_range(65535));
        it.dest_port = $urandom_range(1) ? cur_port :
                       tftp_re_pkg::PortW'($urandom_range(65535));
        push_byte(it);
        sent++;
      end else begin
        k = $urandom_range(99);
        if (k < 55) begin
          op = tftp_re_pkg::OpData;
        end else if (k < 70) begin
          op = tftp_re_pkg::OpAck;
        end else if (k < 82) begin
          op = tftp_re_pkg::OpError;
        end else begin
          op = $urandom_range(1) ? tftp_re_pkg::WordW'($urandom_range(2)) :
               tftp_re_pkg::WordW'($urandom_range(65535));
        end
        k = $urandom_range(99);
        if (k < 10) begin
          blk = '0;
        end else if (k < 15) begin
          blk = '1;
        end else if (k < 70) begin
          blk = tftp_re_pkg::WordW'($urandom_range(1, 8));
        end else begin
          blk = tftp_re_pkg::WordW'($urandom_range(65535));
        end
        k = $urandom_range(99);
        if (k < 3) begin
          nbytes = BlockBytes + 4;
        end else if (k < 5) begin
          nbytes = BlockBytes + $urandom_range(2, 5);
        end else if (k < 13) begin
          nbytes = $urandom_range(1, 3);
        end else begin
          nbytes = $urandom_range(4, 16);
        end
        dport = ($urandom_range(99) < 85) ? cur_port :
                tftp_re_pkg::PortW'($urandom_range(65535));
        send_packet(op, blk, nbytes, dport, ($urandom_range(9) != 0),
                    ($urandom_range(9) == 0) ? $urandom_range(nbytes - 1) : -1);
        sent += nbytes;
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_local_port(input logic [tftp_re_pkg::PortW-1:0] port);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= port;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_port = port;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed packets under the reset port: an ACK of block zero, a short
    // data block, a truncated header, a read request, a data block zero,
    // a data packet to another port and an error packet.
    send_packet(tftp_re_pkg::OpAck, 16'd0, 4, cur_port, 1'b1, -1);
    send_packet(tftp_re_pkg::OpData, 16'd1, 5, cur_port, 1'b1, -1);
    send_packet(tftp_re_pkg::OpData, 16'd2, 2, cur_port, 1'b1, -1);
    send_packet(16'd1, 16'd1, 4, cur_port, 1'b1, -1);
    send_packet(tftp_re_pkg::OpData, 16'd0, 4, cur_port, 1'b1, -1);
    send_packet(tftp_re_pkg::OpData, 16'd3, 4, ~cur_port, 1'b1, -1);
    send_packet(tftp_re_pkg::OpError, 16'd2, 4, cur_port, 1'b1, -1);

    set_local_port(16'h0000);
    random_traffic(220);

    set_local_port(16'hFFFF);
    want_hold = 1'b1;
    random_traffic(220);

    set_local_port(tftp_re_pkg::PortW'($urandom_range(65535)));
    // A data packet for the highest block, sent without idling on either side.
    quiet = 1'b1;
    send_packet(tftp_re_pkg::OpData, 16'hFFFF, QuietBytes, cur_port, 1'b1, -1);
    quiet = 1'b0;
    random_traffic(220);

    set_local_port(tftp_re_pkg::ResetPort);
    random_traffic(220);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending != 0) begin
        $display("%0t: %0d predicted results never arrived", $time, pending);
      end
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
